[rtl/core/chtb_pkg.sv]
// Shared types and field widths for the canonical Huffman table builder.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package chtb_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 5;
    localparam int OFF_W   = 9;
    localparam int CODE_W  = 16;
    localparam int MAXC_W  = 17;
    localparam int TOTAL_W = 12;
    localparam int ACC_W   = 18;

    // Datapath operation requested by the controller for the current cycle.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_ACCEPT,
        OP_SCAN,
        OP_EMIT,
        OP_SEEK
    } t_op;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic load_active;
        logic load_last;
        logic sym_pending;
        logic idx_last;
        logic seek_done;
    } t_status;

endpackage

[rtl/core/chtb_ctrl.sv]
// Controller state machine of the canonical Huffman table builder.
// Depends on chtb_pkg for the operation code and the datapath status.
`timescale 1ns / 1ps

module chtb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  chtb_pkg::t_status i_status,
    output logic              o_busy,
    output chtb_pkg::t_op     o_op
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_SEEK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   w_accept;

    assign w_accept = i_start && !r_busy;
    assign o_busy   = r_busy;

    always_comb begin
        n_state = r_state;
        o_op    = chtb_pkg::OP_IDLE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_op = chtb_pkg::OP_ACCEPT;
                    if (i_status.load_last) begin
                        n_state = S_SCAN;
                    end else if (!i_status.load_active && i_status.sym_pending) begin
                        n_state = S_SEEK;
                    end
                end
            end
            S_SCAN: begin
                o_op = chtb_pkg::OP_SCAN;
                if (i_status.idx_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_op = chtb_pkg::OP_EMIT;
                if (i_status.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SEEK: begin
                o_op = chtb_pkg::OP_SEEK;
                if (i_status.seek_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

`ifndef SYNTHESIS
    a_busy_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag disagrees with controller state");

    a_emit_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && $past(r_state) != S_EMIT) |-> $past(r_state) == S_SCAN)
        else $error("emit pass entered without a scan pass");

    a_seek_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEEK && $past(r_state) != S_SEEK) |-> $past(w_accept))
        else $error("symbol search entered without an accepted request");
`endif

endmodule

[rtl/core/chtb_dp.sv]
// Datapath of the canonical Huffman table builder: count store, code
// accumulators and result registers. Depends on chtb_pkg.
`timescale 1ns / 1ps

module chtb_dp #(
    parameter int CODE_LENGTHS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  chtb_pkg::t_op                i_op,
    input  logic [chtb_pkg::BYTE_W-1:0]  i_table_byte,
    input  logic                         i_start_table,
    output chtb_pkg::t_status            o_status,
    output logic                         o_valid,
    output logic                         o_entry_kind,
    output logic [chtb_pkg::LEN_W-1:0]   o_length_index,
    output logic [chtb_pkg::OFF_W-1:0]   o_offset,
    output logic [chtb_pkg::CODE_W-1:0]  o_first_code,
    output logic [chtb_pkg::MAXC_W-1:0]  o_max_code,
    output logic [chtb_pkg::BYTE_W-1:0]  o_length_count,
    output logic [chtb_pkg::BYTE_W-1:0]  o_symbol,
    output logic [chtb_pkg::CODE_W-1:0]  o_code,
    output logic                         o_oversubscribed,
    output logic                         o_last
);

    localparam int IDX_W = $clog2(CODE_LENGTHS);
    localparam int LP_W  = $clog2(CODE_LENGTHS + 1);
    localparam int BW    = chtb_pkg::BYTE_W;
    localparam int LW    = chtb_pkg::LEN_W;
    localparam int AW    = chtb_pkg::ACC_W;
    localparam int TW    = chtb_pkg::TOTAL_W;
    localparam int RW    = chtb_pkg::MAXC_W;

    // Clamp a code to the size of the code space of a length, then move on
    // to the next length.
    function automatic logic [AW-1:0] clamp_shl(input logic [AW-1:0] value,
                                                input logic [LW-1:0] len);
        logic [AW-1:0] space;
        space = AW'(1) << len;
        return (value > space ? space : value) << 1;
    endfunction

    logic [BW-1:0]    r_counts [CODE_LENGTHS];
    logic [LP_W-1:0]  r_load_pos;
    logic [LP_W-1:0]  r_cur;
    logic [BW-1:0]    r_remaining;
    logic [RW-1:0]    r_running;
    logic [TW-1:0]    r_syms;
    logic             r_overflow;
    logic [IDX_W-1:0] r_idx;
    logic [AW-1:0]    r_acc_code;
    logic [TW-1:0]    r_total;
    logic             r_acc_over;
    logic [BW-1:0]    r_sym_byte;
    logic             r_valid;

    logic             r_entry_kind;
    logic [LW-1:0]    r_length_index;
    logic [chtb_pkg::OFF_W-1:0]  r_offset;
    logic [chtb_pkg::CODE_W-1:0] r_first_code;
    logic [RW-1:0]    r_max_code;
    logic [BW-1:0]    r_length_count;
    logic [BW-1:0]    r_symbol;
    logic [chtb_pkg::CODE_W-1:0] r_code;
    logic             r_oversub;
    logic             r_last;

    logic [LP_W-1:0]  w_eff_load;
    logic [TW-1:0]    w_eff_syms;
    logic [IDX_W-1:0] w_rd_idx;
    logic [BW-1:0]    w_cnt;
    logic [LW-1:0]    w_len;
    logic [AW-1:0]    w_next;
    logic             w_over;
    logic             w_seek_step;
    logic             w_seek_hit;

    assign w_eff_load = i_start_table ? '0 : r_load_pos;
    assign w_eff_syms = i_start_table ? '0 : r_syms;
    assign w_rd_idx   = (i_op == chtb_pkg::OP_SEEK) ? r_cur[IDX_W-1:0] : r_idx;
    assign w_cnt      = r_counts[w_rd_idx];
    assign w_len      = LW'(r_idx) + LW'(1);
    assign w_next     = r_acc_code + AW'(w_cnt);
    assign w_over     = w_next > (AW'(1) << w_len);

    assign w_seek_step = (r_remaining == '0) && (r_cur != LP_W'(CODE_LENGTHS));
    assign w_seek_hit  = (r_remaining != '0);

    assign o_status.load_active = (w_eff_load < LP_W'(CODE_LENGTHS));
    assign o_status.load_last   = (w_eff_load == LP_W'(CODE_LENGTHS - 1));
    assign o_status.sym_pending = (w_eff_syms != '0);
    assign o_status.idx_last    = (r_idx == IDX_W'(CODE_LENGTHS - 1));
    assign o_status.seek_done   = w_seek_hit || (r_cur == LP_W'(CODE_LENGTHS));

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos  <= '0;
            r_cur       <= '0;
            r_remaining <= '0;
            r_running   <= '0;
            r_syms      <= '0;
            r_overflow  <= 1'b0;
            r_idx       <= '0;
            r_acc_code  <= '0;
            r_total     <= '0;
            r_acc_over  <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (i_op)
                chtb_pkg::OP_ACCEPT: begin
                    if (i_start_table) begin
                        r_cur       <= '0;
                        r_remaining <= '0;
                        r_running   <= '0;
                        r_syms      <= '0;
                        r_overflow  <= 1'b0;
                    end
                    if (o_status.load_active) begin
                        r_load_pos <= w_eff_load + LP_W'(1);
                        if (o_status.load_last) begin
                            r_idx      <= '0;
                            r_acc_code <= '0;
                            r_total    <= '0;
                            r_acc_over <= 1'b0;
                        end
                    end
                end
                chtb_pkg::OP_SCAN: begin
                    if (o_status.idx_last) begin
                        r_overflow  <= r_acc_over | w_over;
                        r_syms      <= r_total + TW'(w_cnt);
                        r_cur       <= '0;
                        r_remaining <= '0;
                        r_running   <= '0;
                        r_idx       <= '0;
                        r_acc_code  <= '0;
                        r_total     <= '0;
                    end else begin
                        r_acc_over <= r_acc_over | w_over;
                        r_acc_code <= clamp_shl(w_next, w_len);
                        r_total    <= r_total + TW'(w_cnt);
                        r_idx      <= r_idx + IDX_W'(1);
                    end
                end
                chtb_pkg::OP_EMIT: begin
                    r_valid    <= 1'b1;
                    r_total    <= r_total + TW'(w_cnt);
                    r_acc_code <= clamp_shl(w_next, w_len);
                    r_idx      <= o_status.idx_last ? '0 : r_idx + IDX_W'(1);
                end
                chtb_pkg::OP_SEEK: begin
                    if (w_seek_step) begin
                        if (r_cur != '0) begin
                            r_running <= RW'(clamp_shl(AW'(r_running), LW'(r_cur)));
                        end
                        r_cur       <= r_cur + LP_W'(1);
                        r_remaining <= w_cnt;
                    end else if (!w_seek_hit) begin
                        // Lengths ran out with symbols still expected.
                        r_syms <= '0;
                    end else begin
                        r_valid     <= 1'b1;
                        r_running   <= r_running + RW'(1);
                        r_remaining <= r_remaining - BW'(1);
                        r_syms      <= r_syms - TW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Count store; it is written only during loading.
    always_ff @(posedge i_clk) begin
        if (i_op == chtb_pkg::OP_ACCEPT && o_status.load_active) begin
            r_counts[w_eff_load[IDX_W-1:0]] <= i_table_byte;
        end
    end

    // Symbol byte and result payload. The emit pass reuses r_total as the
    // running offset, since the scan pass leaves it cleared.
    always_ff @(posedge i_clk) begin
        if (i_op == chtb_pkg::OP_ACCEPT) begin
            r_sym_byte <= i_table_byte;
        end
        if (i_op == chtb_pkg::OP_EMIT) begin
            r_entry_kind   <= 1'b0;
            r_length_index <= w_len;
            r_offset       <= (r_total > TW'(511)) ? chtb_pkg::OFF_W'(511)
                                                   : r_total[chtb_pkg::OFF_W-1:0];
            r_first_code   <= (r_acc_code > AW'(65535)) ? chtb_pkg::CODE_W'(65535)
                                                        : r_acc_code[chtb_pkg::CODE_W-1:0];
            r_max_code     <= (w_cnt != '0) ? w_next[RW-1:0] : '0;
            r_length_count <= w_cnt;
            r_symbol       <= '0;
            r_code         <= '0;
            r_oversub      <= r_overflow;
            r_last         <= o_status.idx_last && (r_syms == '0);
        end else if (i_op == chtb_pkg::OP_SEEK && !w_seek_step && w_seek_hit) begin
            r_entry_kind   <= 1'b1;
            r_length_index <= LW'(r_cur);
            r_offset       <= '0;
            r_first_code   <= '0;
            r_max_code     <= '0;
            r_length_count <= '0;
            r_symbol       <= r_sym_byte;
            r_code         <= r_running[chtb_pkg::CODE_W-1:0];
            r_oversub      <= r_overflow;
            r_last         <= (r_syms == TW'(1));
        end
    end

    assign o_valid          = r_valid;
    assign o_entry_kind     = r_entry_kind;
    assign o_length_index   = r_length_index;
    assign o_offset         = r_offset;
    assign o_first_code     = r_first_code;
    assign o_max_code       = r_max_code;
    assign o_length_count   = r_length_count;
    assign o_symbol         = r_symbol;
    assign o_code           = r_code;
    assign o_oversubscribed = r_oversub;
    assign o_last           = r_last;

`ifndef SYNTHESIS
    a_valid_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_op == chtb_pkg::OP_EMIT || i_op == chtb_pkg::OP_SEEK))
        else $error("result strobe without an emit or search step");

    a_positions_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_pos <= LP_W'(CODE_LENGTHS)) && (r_cur <= LP_W'(CODE_LENGTHS)))
        else $error("load position or current length beyond the last length");

    a_last_symbol_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_entry_kind && r_last) |-> (r_syms == '0))
        else $error("last symbol marked while symbols remain");
`endif

endmodule

[rtl/core/canonical_huffman_table_builder_top.sv]
// Top level of the canonical Huffman table builder: controller plus datapath.
// Depends on chtb_pkg, chtb_ctrl and chtb_dp.
`timescale 1ns / 1ps

// The block takes a JPEG-style table specification one byte per request:
// CODE_LENGTHS count bytes, then the symbol values in order. A request is
// taken at a clock edge where start is high and busy is low; i_start_table
// on a request throws away any partly loaded table and treats the byte as
// the first count. Count bytes do not raise busy, except the last one,
// which keeps busy high while a scan pass over the count store first
// sums the counts and checks the code space, then an emit pass presents
// one per-length entry per cycle. A symbol byte is placed at the current
// length when that length still has free codes; otherwise the datapath
// first walks on to a later length, one length per cycle, and busy stays
// high until the symbol is placed. Results appear for one cycle each with
// o_valid high and cannot be held off, so the receiver must take every
// strobe. Symbol bytes beyond the table's total give no result.
module canonical_huffman_table_builder_top #(
    parameter int CODE_LENGTHS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [chtb_pkg::BYTE_W-1:0]  i_table_byte,
    input  logic                         i_start_table,
    output logic                         busy,
    output logic                         o_valid,
    output logic                         o_entry_kind,
    output logic [chtb_pkg::LEN_W-1:0]   o_length_index,
    output logic [chtb_pkg::OFF_W-1:0]   o_offset,
    output logic [chtb_pkg::CODE_W-1:0]  o_first_code,
    output logic [chtb_pkg::MAXC_W-1:0]  o_max_code,
    output logic [chtb_pkg::BYTE_W-1:0]  o_length_count,
    output logic [chtb_pkg::BYTE_W-1:0]  o_symbol,
    output logic [chtb_pkg::CODE_W-1:0]  o_code,
    output logic                         o_oversubscribed,
    output logic                         o_last
);

    // Operation requested of the datapath in this cycle, and the status
    // the controller steers by.
    chtb_pkg::t_op     w_op;
    chtb_pkg::t_status w_status;

    // The controller sequences loading, the two passes over the counts and
    // the per-symbol length walk.
    chtb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_op     (w_op)
    );

    // The datapath holds the counts, the canonical code state and the
    // registered result.
    chtb_dp #(
        .CODE_LENGTHS (CODE_LENGTHS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .i_table_byte     (i_table_byte),
        .i_start_table    (i_start_table),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_entry_kind     (o_entry_kind),
        .o_length_index   (o_length_index),
        .o_offset         (o_offset),
        .o_first_code     (o_first_code),
        .o_max_code       (o_max_code),
        .o_length_count   (o_length_count),
        .o_symbol         (o_symbol),
        .o_code           (o_code),
        .o_oversubscribed (o_oversubscribed),
        .o_last           (o_last)
    );

endmodule
